@@ design/utf8v_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CODE_W  = 21;
    localparam int unsigned COUNT_W = 2;

    typedef enum logic [1:0] {
        VERDICT_PENDING = 2'd0,
        VERDICT_VALID   = 2'd1,
        VERDICT_INVALID = 2'd2
    } verdict_t;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CODE_W-1:0]  code_t;

    localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7f;
    localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hc2;
    localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hdf;
    localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD3_MAX   = 8'hef;
    localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD4_MAX   = 8'hf4;
    localparam logic [1:0]        CONT_TAG    = 2'b10;

    localparam code_t MIN_THREE_BYTE = 21'h000800;
    localparam code_t MIN_FOUR_BYTE  = 21'h010000;
    localparam code_t SURROGATE_LO   = 21'h00d800;
    localparam code_t SURROGATE_HI   = 21'h00dfff;
    localparam code_t CODE_MAX       = 21'h10ffff;

    localparam count_t LEN_TWO_CONT   = 2'd2;
    localparam count_t LEN_THREE_CONT = 2'd3;

endpackage

@@ design/utf8_stream_validator.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 check of a byte string, one byte per request, verdict on the
// last byte.
//
//   channel | direction | tdata                    | tlast
//   s_axis  | in        | [7:0] text_byte          | end_of_text
//   m_axis  | out       | [1:0] verdict, [7:2] zero| string_done
//
// One byte per cycle while m_axis_tready is high; each byte passes the input register,
// then one pass of decode logic into the result register.
// Every byte gives one result; the verdict is pending except on the last byte.
// Synchronous active-low reset clears the pipeline valids and decode state.
// A stalled result holds both registers; s_axis_tready falls only when both
// stages are full and m_axis_tready is low.
// ----------------------------------------------------------------------------
module utf8_stream_validator
    import utf8v_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] text_byte
    input  logic                s_axis_tlast,

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [BYTE_W-1:0]   m_axis_tdata,   // [1:0] verdict, [7:2] zero
    output logic                m_axis_tlast
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic              out_valid_reg;
    verdict_t          verdict_reg;
    verdict_t          verdict_next;
    logic              done_reg;

    count_t            pend_reg;
    count_t            pend_next;
    count_t            len_reg;
    count_t            len_next;
    code_t             acc_reg;
    code_t             acc_next;
    logic              err_reg;
    logic              err_next;

    logic              out_ready;
    logic              in_ready;
    logic              load;

    count_t            pend_step;
    count_t            len_step;
    code_t             acc_step;
    code_t             acc_shift;
    logic              err_step;
    logic              rejected;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign in_ready      = !in_valid_reg || out_ready;
    assign load          = in_valid_reg && out_ready;
    assign s_axis_tready = in_ready;

    assign acc_shift = {acc_reg[CODE_W-7:0], in_byte_reg[5:0]};

    always_comb begin
        rejected = 1'b0;
        if (len_reg == LEN_TWO_CONT && acc_shift < MIN_THREE_BYTE) begin
            rejected = 1'b1;
        end
        if (len_reg == LEN_THREE_CONT && acc_shift < MIN_FOUR_BYTE) begin
            rejected = 1'b1;
        end
        if (acc_shift >= SURROGATE_LO && acc_shift <= SURROGATE_HI) begin
            rejected = 1'b1;
        end
        if (acc_shift > CODE_MAX) begin
            rejected = 1'b1;
        end
    end

    always_comb begin
        pend_step = pend_reg;
        len_step  = len_reg;
        acc_step  = acc_reg;
        err_step  = err_reg;
        if (!err_reg) begin
            if (pend_reg != '0) begin
                if (in_byte_reg[7:6] != CONT_TAG) begin
                    err_step = 1'b1;
                end else begin
                    acc_step  = acc_shift;
                    pend_step = pend_reg - count_t'(1);
                    if (pend_reg == count_t'(1)) begin
                        err_step = rejected;
                        acc_step = '0;
                        len_step = '0;
                    end
                end
            end else if (in_byte_reg == '0) begin
                err_step = 1'b1;
            end else if (in_byte_reg <= ASCII_MAX) begin
                err_step = 1'b0;
            end else if (in_byte_reg >= LEAD2_MIN && in_byte_reg <= LEAD2_MAX) begin
                acc_step  = code_t'(in_byte_reg[4:0]);
                len_step  = count_t'(1);
                pend_step = count_t'(1);
            end else if (in_byte_reg >= LEAD3_MIN && in_byte_reg <= LEAD3_MAX) begin
                acc_step  = code_t'(in_byte_reg[3:0]);
                len_step  = count_t'(2);
                pend_step = count_t'(2);
            end else if (in_byte_reg >= LEAD4_MIN && in_byte_reg <= LEAD4_MAX) begin
                acc_step  = code_t'(in_byte_reg[2:0]);
                len_step  = count_t'(3);
                pend_step = count_t'(3);
            end else begin
                err_step = 1'b1;
            end
        end
    end

    always_comb begin
        pend_next    = pend_step;
        len_next     = len_step;
        acc_next     = acc_step;
        err_next     = err_step;
        verdict_next = VERDICT_PENDING;
        if (err_step) begin
            pend_next = '0;
            len_next  = '0;
            acc_next  = '0;
        end
        if (in_last_reg) begin
            verdict_next = (err_step || pend_step != '0) ? VERDICT_INVALID : VERDICT_VALID;
            pend_next    = '0;
            len_next     = '0;
            acc_next     = '0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= '0;
            len_reg       <= '0;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (load) begin
                pend_reg <= pend_next;
                len_reg  <= len_next;
                acc_reg  <= acc_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (load) begin
            verdict_reg <= verdict_next;
            done_reg    <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(BYTE_W-2){1'b0}}, verdict_reg};
    assign m_axis_tlast  = done_reg;

`ifndef SYNTHESIS
    a_done_has_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (verdict_reg != VERDICT_PENDING)))
        else $error("verdict and string_done disagree");

    a_idle_seq_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == '0) |-> (len_reg == '0 && acc_reg == '0))
        else $error("sequence state left over with nothing pending");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_last_reg) |=> (pend_reg == '0 && err_reg == 1'b0))
        else $error("state not cleared after last byte");
`endif

endmodule
